FILE: design/adnp_pkg.sv
// ----------------------------------------------------------------------------
// adnp_pkg: shared types and constants for the ascii decimal number parser
// Character codes, fixed-point sizing, sequencer states and the 10^k table.
// ----------------------------------------------------------------------------
package adnp_pkg;

  localparam int FRACTION_BITS       = 16;
  localparam int MAX_FRACTION_DIGITS = 9;

  localparam int VALUE_W = 48;
  localparam int COUNT_W = 8;
  localparam int INT_W   = 32;
  localparam int FRAC_W  = 30;
  localparam int K_W     = 4;
  localparam int DIV_CNT_W = $clog2(FRACTION_BITS + 2);

  // integer part limit: min(2^(47-FRACTION_BITS)-1, 2^32-1)
  localparam longint unsigned INT_LIMIT =
    ((47 - FRACTION_BITS) >= 32) ? 64'hFFFF_FFFF
                                 : ((64'd1 << (47 - FRACTION_BITS)) - 64'd1);

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPACE,
    ST_INT,
    ST_FRAC,
    ST_DIV
  } state_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == '1) ? v : v + COUNT_W'(1);
  endfunction

  // 10^k for k up to MAX_FRACTION_DIGITS
  function automatic logic [FRAC_W-1:0] pow10(input logic [K_W-1:0] k);
    logic [FRAC_W-1:0] p;
    p = FRAC_W'(1);
    case (k)
      4'd0: p = FRAC_W'(1);
      4'd1: p = FRAC_W'(10);
      4'd2: p = FRAC_W'(100);
      4'd3: p = FRAC_W'(1000);
      4'd4: p = FRAC_W'(10000);
      4'd5: p = FRAC_W'(100000);
      4'd6: p = FRAC_W'(1000000);
      4'd7: p = FRAC_W'(10000000);
      4'd8: p = FRAC_W'(100000000);
      4'd9: p = FRAC_W'(1000000000);
      default: p = FRAC_W'(1);
    endcase
    pow10 = p;
  endfunction

endpackage

FILE: design/ascii_decimal_number_parser.sv
// A consumed byte updates the accumulators; the terminating byte starts a restoring
// division of the fraction by 10^k, one quotient bit per cycle for FRACTION_BITS (16)
// quotient bits, then the result is loaded into the output register once it is free.
// Throughput: 1 byte per cycle inside a number; after the terminating byte tready stays
// low through the division, plus any wait for the output register to drain.
// Reset: rst (synchronous) returns to idle, drops tvalid, sets fraction_enable to 1.
// ----------------------------------------------------------------------------
// ascii_decimal_number_parser
// Parses ASCII decimal numbers from a byte stream into signed fixed point.
// ----------------------------------------------------------------------------
module ascii_decimal_number_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,      // fraction_enable
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tuser,   // start_req
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [47:0] value, [55:48] bytes_used,
                                      // [63:56] integer_digits, [71:64] fraction_digits
  output logic        m_axis_tuser    // overflow
);

  localparam int FB = adnp_pkg::FRACTION_BITS;
  localparam int IW = adnp_pkg::INT_W;
  localparam int FW = adnp_pkg::FRAC_W;
  localparam int CW = adnp_pkg::COUNT_W;
  localparam int VW = adnp_pkg::VALUE_W;
  localparam int NW = adnp_pkg::DIV_CNT_W;

  adnp_pkg::state_t state, state_next;

  logic          fraction_enable;
  logic          negative, negative_next;
  logic [IW-1:0] int_acc, int_acc_next;
  logic [FW-1:0] frac_acc, frac_acc_next;
  logic [CW-1:0] byte_cnt, byte_cnt_next;
  logic [CW-1:0] int_digits, int_digits_next;
  logic [CW-1:0] frac_digits, frac_digits_next;
  logic          ovf, ovf_next;

  // divider datapath
  logic [FW-1:0] rem, rem_next;
  logic [FW-1:0] den, den_next;
  logic [FB:0]   quo, quo_next;
  logic [NW-1:0] div_cnt, div_cnt_next;

  logic          out_valid_next;
  logic [71:0]   out_data_next;
  logic          out_user_next;

  logic          s_accept;
  logic          terminate;
  logic          int_path, frac_path;
  logic [7:0]    b;
  logic [3:0]    d;
  logic          is_digit, is_point, is_ws, is_sign;
  logic [IW+3:0] int_mul;
  logic [FW:0]   rem_dbl;
  logic [VW-1:0] magnitude, value_out;
  logic [adnp_pkg::K_W-1:0] k;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign b        = s_axis_tdata;
  assign d        = 4'(b - adnp_pkg::CH_ZERO);
  assign is_digit = (b >= adnp_pkg::CH_ZERO) && (b <= adnp_pkg::CH_NINE);
  assign is_point = fraction_enable && (b == adnp_pkg::CH_POINT);
  assign is_ws    = (b != 8'h00) && (b <= adnp_pkg::CH_SPACE);
  assign is_sign  = (b == adnp_pkg::CH_MINUS) || (b == adnp_pkg::CH_PLUS);

  assign rem_dbl   = {rem, 1'b0};
  assign magnitude = (VW'(int_acc) << FB) + VW'(quo[FB-1:0]);
  assign value_out = negative ? (VW'(0) - magnitude) : magnitude;

  always_comb begin
    unique case (state) inside
      adnp_pkg::ST_IDLE, adnp_pkg::ST_SPACE,
      adnp_pkg::ST_INT, adnp_pkg::ST_FRAC: s_axis_tready = 1'b1;
      default:                             s_axis_tready = 1'b0;
    endcase
  end

  always_comb begin
    adnp_pkg::state_t p;
    p                = state;
    state_next       = state;
    negative_next    = negative;
    int_acc_next     = int_acc;
    frac_acc_next    = frac_acc;
    byte_cnt_next    = byte_cnt;
    int_digits_next  = int_digits;
    frac_digits_next = frac_digits;
    ovf_next         = ovf;
    rem_next         = rem;
    den_next         = den;
    quo_next         = quo;
    div_cnt_next     = div_cnt;
    out_valid_next   = m_axis_tvalid && !m_axis_tready;
    out_data_next    = m_axis_tdata;
    out_user_next    = m_axis_tuser;
    terminate        = 1'b0;
    int_path         = 1'b0;
    frac_path        = 1'b0;
    int_mul          = '0;
    k                = '0;

    if (s_accept) begin
      if (s_axis_tuser) begin
        negative_next    = 1'b0;
        int_acc_next     = '0;
        frac_acc_next    = '0;
        byte_cnt_next    = '0;
        int_digits_next  = '0;
        frac_digits_next = '0;
        ovf_next         = 1'b0;
        p                = adnp_pkg::ST_SPACE;
        state_next       = adnp_pkg::ST_SPACE;
      end

      unique case (p)
        adnp_pkg::ST_SPACE: begin
          if (is_ws) begin
            byte_cnt_next = adnp_pkg::sat_inc(byte_cnt_next);
          end else if (is_sign) begin
            negative_next = (b == adnp_pkg::CH_MINUS);
            byte_cnt_next = adnp_pkg::sat_inc(byte_cnt_next);
            state_next    = adnp_pkg::ST_INT;
          end else begin
            int_path = 1'b1;
          end
        end
        adnp_pkg::ST_INT:  int_path  = 1'b1;
        adnp_pkg::ST_FRAC: frac_path = 1'b1;
        default: ;
      endcase

      if (int_path) begin
        state_next = adnp_pkg::ST_INT;
        if (is_digit) begin
          // acc * 10 + d as two shifted adds
          int_mul = ((IW+4)'(int_acc_next) << 3) + ((IW+4)'(int_acc_next) << 1)
                    + (IW+4)'(d);
          if (64'(int_mul) > adnp_pkg::INT_LIMIT) begin
            int_acc_next = IW'(adnp_pkg::INT_LIMIT);
            ovf_next     = 1'b1;
          end else begin
            int_acc_next = int_mul[IW-1:0];
          end
          int_digits_next = adnp_pkg::sat_inc(int_digits_next);
          byte_cnt_next   = adnp_pkg::sat_inc(byte_cnt_next);
        end else if (is_point) begin
          byte_cnt_next = adnp_pkg::sat_inc(byte_cnt_next);
          state_next    = adnp_pkg::ST_FRAC;
        end else begin
          terminate = 1'b1;
        end
      end

      if (frac_path) begin
        if (is_digit) begin
          if (frac_digits_next < CW'(adnp_pkg::MAX_FRACTION_DIGITS)) begin
            frac_acc_next = FW'((frac_acc_next << 3) + (frac_acc_next << 1) + FW'(d));
          end
          frac_digits_next = adnp_pkg::sat_inc(frac_digits_next);
          byte_cnt_next    = adnp_pkg::sat_inc(byte_cnt_next);
        end else begin
          terminate = 1'b1;
        end
      end

      if (terminate) begin
        k = (frac_digits_next < CW'(adnp_pkg::MAX_FRACTION_DIGITS))
            ? adnp_pkg::K_W'(frac_digits_next)
            : adnp_pkg::K_W'(adnp_pkg::MAX_FRACTION_DIGITS);
        rem_next     = frac_acc_next;
        den_next     = adnp_pkg::pow10(k);
        quo_next     = '0;
        div_cnt_next = '0;
        state_next   = adnp_pkg::ST_DIV;
      end
    end

    if (state == adnp_pkg::ST_DIV) begin
      if (div_cnt != NW'(FB)) begin
        // one restoring step: remainder stays below the divisor
        if (rem_dbl >= (FW+1)'(den)) begin
          rem_next = FW'(rem_dbl - (FW+1)'(den));
          quo_next = {quo[FB-1:0], 1'b1};
        end else begin
          rem_next = rem_dbl[FW-1:0];
          quo_next = {quo[FB-1:0], 1'b0};
        end
        div_cnt_next = div_cnt + NW'(1);
      end else if (!m_axis_tvalid || m_axis_tready) begin
        out_valid_next = 1'b1;
        out_data_next  = {frac_digits, int_digits, byte_cnt, value_out};
        out_user_next  = ovf;
        state_next     = adnp_pkg::ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= adnp_pkg::ST_IDLE;
      fraction_enable <= 1'b1;
      m_axis_tvalid   <= 1'b0;
    end else begin
      state         <= state_next;
      m_axis_tvalid <= out_valid_next;
      if (cfg_we) begin
        fraction_enable <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    negative     <= negative_next;
    int_acc      <= int_acc_next;
    frac_acc     <= frac_acc_next;
    byte_cnt     <= byte_cnt_next;
    int_digits   <= int_digits_next;
    frac_digits  <= frac_digits_next;
    ovf          <= ovf_next;
    rem          <= rem_next;
    den          <= den_next;
    quo          <= quo_next;
    div_cnt      <= div_cnt_next;
    m_axis_tdata <= out_data_next;
    m_axis_tuser <= out_user_next;
  end

  // a terminating byte always hands over to the divider
  a_term_to_div: assert property (@(posedge clk) disable iff (rst)
    s_accept && terminate |=> state == adnp_pkg::ST_DIV)
    else $error("terminating byte did not start division");

  // restoring division keeps the remainder under the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == adnp_pkg::ST_DIV |-> rem < den)
    else $error("division remainder out of range");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    state == adnp_pkg::ST_DIV |-> div_cnt <= NW'(FB))
    else $error("division step count overran");

  // a result is only loaded once all quotient bits are in
  a_load_done: assert property (@(posedge clk) disable iff (rst)
    state == adnp_pkg::ST_DIV && state_next == adnp_pkg::ST_IDLE |->
      div_cnt == NW'(FB))
    else $error("result loaded before division finished");

endmodule
